>>> rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the blit clip command setup
// Field widths, register codes, the configuration bundle and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

  // default parameter values
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned ADDR_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int unsigned SCREEN_W    = 14;
  localparam int unsigned STRIDE_W    = 18;
  localparam int unsigned BPP_W       = 3;
  localparam int unsigned SRC_POS_W   = 14;
  localparam int unsigned SIZE_W      = 14;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned OUT_ADDR_W  = 32;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 168;

  // register reset values
  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 14'd1024;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 14'd768;
  localparam logic [STRIDE_W-1:0] SCREEN_STRIDE_RST = 18'd4096;
  localparam logic [BPP_W-1:0]    BPP_RST           = 3'd4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_SCREEN_STRIDE = 2'd2,
    REG_BPP           = 2'd3
  } cfg_reg_e;

  // operation codes
  localparam logic OP_FILL = 1'b0;
  localparam logic OP_COPY = 1'b1;

  // configuration bundle seen by the pipeline
  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [STRIDE_W-1:0] screen_stride;
    logic [BPP_W-1:0]    bpp;
  } cfg_t;

  // width of the shifted source coordinates for a given coordinate width
  function automatic int unsigned src_coord_width(input int unsigned cw);
    return ((cw > 15) ? cw : 15) + 2;
  endfunction

endpackage

`default_nettype wire

>>> rtl/blit_clip_command_setup.sv
// ----------------------------------------------------------------------------
// blit_clip_command_setup: blit request clipping and command descriptor setup
// Intersects each fill or copy request with its clip rectangle and the screen
// and turns the result into one command descriptor.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per word (tuser = operation), m_axis one
//   descriptor per word (tuser = command_operation). A request that clips
//   to nothing produces no descriptor and is simply consumed.
//   The cfg channel writes screen_width (0), screen_height (1),
//   screen_stride (2) and bytes_per_pixel (3); cfg_ready_o is always high.
//   Write it only while no request is in flight.
//   The pipeline has 4 register stages: edge clamping, size and source
//   shift, row/column products, address sums. One request is taken every
//   cycle while the pipeline is not stalled; the products stage, one
//   multiply per address term, sets the per-stage depth.
//   Reset empties the pipeline and loads the default 1024x768 screen with
//   a 4096-byte stride and 4 bytes per pixel. When m_axis stalls, each
//   stage holds its word and s_axis_tready falls once the stages ahead are
//   full; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module blit_clip_command_setup #(
  parameter int unsigned COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH  = bcs_pkg::ADDR_WIDTH_DEF,
  localparam int unsigned InDataW = ((8 * COORD_WIDTH + 60 + 7) / 8) * 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // whole_left, whole_top, whole_right, whole_bottom, clip_left, clip_top,
  // clip_right, clip_bottom, source_x, source_y, fill_color, zero pad
  input  wire logic [InDataW-1:0]               s_axis_tdata,
  // operation
  input  wire logic                             s_axis_tuser,
  // descriptor stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // dest_address, dest_stride, command_width, command_height,
  // source_address, source_stride, command_color, command_bpp, zero pad
  output logic [bcs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // command_operation
  output logic                                  m_axis_tuser,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bcs_pkg::*;

  localparam int unsigned SxW      = src_coord_width(COORD_WIDTH);
  localparam int unsigned SrcXLsb  = 8 * COORD_WIDTH;
  localparam int unsigned SrcYLsb  = SrcXLsb + SRC_POS_W;
  localparam int unsigned ColorLsb = SrcYLsb + SRC_POS_W;
  localparam int unsigned OutUsed  = 2 * OUT_ADDR_W + 2 * STRIDE_W + 2 * SIZE_W
                                     + COLOR_W + BPP_W;

  cfg_t cfg;

  logic signed [COORD_WIDTH-1:0] whole_left, whole_top, whole_right, whole_bottom;
  logic signed [COORD_WIDTH-1:0] clip_left, clip_top, clip_right, clip_bottom;
  logic [SRC_POS_W-1:0]          source_x, source_y;
  logic [COLOR_W-1:0]            fill_color;

  logic                          mid_valid, mid_ready, mid_op;
  logic [SIZE_W-1:0]             mid_left, mid_top, mid_width, mid_height;
  logic [SxW-1:0]                mid_sx, mid_sy;
  logic [COLOR_W-1:0]            mid_color;

  logic [OUT_ADDR_W-1:0]         dest_address, source_address;
  logic [STRIDE_W-1:0]           dest_stride, source_stride;
  logic [SIZE_W-1:0]             command_width, command_height;
  logic [COLOR_W-1:0]            command_color;
  logic [BPP_W-1:0]              command_bpp;

  // request word unpacking
  always_comb begin
    whole_left   = s_axis_tdata[0 * COORD_WIDTH +: COORD_WIDTH];
    whole_top    = s_axis_tdata[1 * COORD_WIDTH +: COORD_WIDTH];
    whole_right  = s_axis_tdata[2 * COORD_WIDTH +: COORD_WIDTH];
    whole_bottom = s_axis_tdata[3 * COORD_WIDTH +: COORD_WIDTH];
    clip_left    = s_axis_tdata[4 * COORD_WIDTH +: COORD_WIDTH];
    clip_top     = s_axis_tdata[5 * COORD_WIDTH +: COORD_WIDTH];
    clip_right   = s_axis_tdata[6 * COORD_WIDTH +: COORD_WIDTH];
    clip_bottom  = s_axis_tdata[7 * COORD_WIDTH +: COORD_WIDTH];
    source_x     = s_axis_tdata[SrcXLsb +: SRC_POS_W];
    source_y     = s_axis_tdata[SrcYLsb +: SRC_POS_W];
    fill_color   = s_axis_tdata[ColorLsb +: COLOR_W];
  end

  bcs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bcs_clip #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_clip (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .op_i           (s_axis_tuser),
    .whole_left_i   (whole_left),
    .whole_top_i    (whole_top),
    .whole_right_i  (whole_right),
    .whole_bottom_i (whole_bottom),
    .clip_left_i    (clip_left),
    .clip_top_i     (clip_top),
    .clip_right_i   (clip_right),
    .clip_bottom_i  (clip_bottom),
    .source_x_i     (source_x),
    .source_y_i     (source_y),
    .color_i        (fill_color),
    .out_valid_o    (mid_valid),
    .out_ready_i    (mid_ready),
    .out_op_o       (mid_op),
    .out_left_o     (mid_left),
    .out_top_o      (mid_top),
    .out_width_o    (mid_width),
    .out_height_o   (mid_height),
    .out_sx_o       (mid_sx),
    .out_sy_o       (mid_sy),
    .out_color_o    (mid_color)
  );

  bcs_addr #(
    .COORD_WIDTH (COORD_WIDTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_addr (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (mid_valid),
    .in_ready_o        (mid_ready),
    .op_i              (mid_op),
    .left_i            (mid_left),
    .top_i             (mid_top),
    .width_i           (mid_width),
    .height_i          (mid_height),
    .sx_i              (mid_sx),
    .sy_i              (mid_sy),
    .color_i           (mid_color),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_op_o          (m_axis_tuser),
    .out_dest_addr_o   (dest_address),
    .out_dest_stride_o (dest_stride),
    .out_width_o       (command_width),
    .out_height_o      (command_height),
    .out_src_addr_o    (source_address),
    .out_src_stride_o  (source_stride),
    .out_color_o       (command_color),
    .out_bpp_o         (command_bpp)
  );

  // descriptor word packing, first field in the low bits
  assign m_axis_tdata = {{(OUT_TDATA_W-OutUsed){1'b0}}, command_bpp, command_color,
                         source_stride, source_address, command_height,
                         command_width, dest_stride, dest_address};

endmodule

`default_nettype wire

>>> rtl/bcs_cfg.sv
// ----------------------------------------------------------------------------
// bcs_cfg: screen configuration registers
// Decodes register writes and holds screen size, stride and pixel size.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bcs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [bcs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output bcs_pkg::cfg_t                         cfg_o
);
  import bcs_pkg::*;

  cfg_t cfg_d, cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SCREEN_WIDTH:  cfg_d.screen_width  = cfg_data_i[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height = cfg_data_i[SCREEN_W-1:0];
        REG_SCREEN_STRIDE: cfg_d.screen_stride = cfg_data_i[STRIDE_W-1:0];
        REG_BPP:           cfg_d.bpp           = cfg_data_i[BPP_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
      cfg_q.screen_stride <= SCREEN_STRIDE_RST;
      cfg_q.bpp           <= BPP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/bcs_clip.sv
// ----------------------------------------------------------------------------
// bcs_clip: rectangle intersection stages
// Stage 1 clamps the edges against clip and screen, stage 2 drops empty
// requests and forms the clipped size and the shifted source point.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_clip #(
  parameter int unsigned COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
  localparam int unsigned SxW = bcs_pkg::src_coord_width(COORD_WIDTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bcs_pkg::cfg_t                    cfg_i,
  // request side
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             op_i,
  input  wire logic signed [COORD_WIDTH-1:0]    whole_left_i,
  input  wire logic signed [COORD_WIDTH-1:0]    whole_top_i,
  input  wire logic signed [COORD_WIDTH-1:0]    whole_right_i,
  input  wire logic signed [COORD_WIDTH-1:0]    whole_bottom_i,
  input  wire logic signed [COORD_WIDTH-1:0]    clip_left_i,
  input  wire logic signed [COORD_WIDTH-1:0]    clip_top_i,
  input  wire logic signed [COORD_WIDTH-1:0]    clip_right_i,
  input  wire logic signed [COORD_WIDTH-1:0]    clip_bottom_i,
  input  wire logic [bcs_pkg::SRC_POS_W-1:0]    source_x_i,
  input  wire logic [bcs_pkg::SRC_POS_W-1:0]    source_y_i,
  input  wire logic [bcs_pkg::COLOR_W-1:0]      color_i,
  // clipped side
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_op_o,
  output logic [bcs_pkg::SIZE_W-1:0]            out_left_o,
  output logic [bcs_pkg::SIZE_W-1:0]            out_top_o,
  output logic [bcs_pkg::SIZE_W-1:0]            out_width_o,
  output logic [bcs_pkg::SIZE_W-1:0]            out_height_o,
  output logic [SxW-1:0]                        out_sx_o,
  output logic [SxW-1:0]                        out_sy_o,
  output logic [bcs_pkg::COLOR_W-1:0]           out_color_o
);
  import bcs_pkg::*;

  localparam int unsigned ExtW = SxW - 1;

  // ---------------- stage 1: edge clamping ----------------
  logic                   s1_en;
  logic                   s1_valid_d, s1_valid_q;
  logic signed [ExtW-1:0] wl_x, wt_x, wr_x, wb_x, cl_x, ct_x, cr_x, cb_x;
  logic signed [ExtW-1:0] sw_x, sh_x;
  logic signed [ExtW-1:0] lmax, tmax, rmin, bmin;
  logic signed [ExtW-1:0] left_d, top_d, right_d, bottom_d;
  logic signed [ExtW-1:0] s1_left_q, s1_top_q, s1_right_q, s1_bottom_q;
  logic signed [ExtW-1:0] s1_wl_q, s1_wt_q;
  logic                   s1_op_q;
  logic [SRC_POS_W-1:0]   s1_srcx_q, s1_srcy_q;
  logic [COLOR_W-1:0]     s1_color_q;

  // ---------------- stage 2: extents ----------------
  logic                   s2_en;
  logic                   s2_valid_d, s2_valid_q;
  logic                   nonempty;
  logic signed [ExtW-1:0] width_x, height_x;
  logic signed [SxW-1:0]  dx, dy;
  logic [SxW-1:0]         sx_d, sy_d;
  logic                   s2_op_q;
  logic [SIZE_W-1:0]      s2_left_q, s2_top_q, s2_width_q, s2_height_q;
  logic [SxW-1:0]         s2_sx_q, s2_sy_q;
  logic [COLOR_W-1:0]     s2_color_q;

  // stall chain
  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // sign extension of all edges, zero extension of the screen bounds
  always_comb begin
    wl_x = {{(ExtW-COORD_WIDTH){whole_left_i[COORD_WIDTH-1]}},   whole_left_i};
    wt_x = {{(ExtW-COORD_WIDTH){whole_top_i[COORD_WIDTH-1]}},    whole_top_i};
    wr_x = {{(ExtW-COORD_WIDTH){whole_right_i[COORD_WIDTH-1]}},  whole_right_i};
    wb_x = {{(ExtW-COORD_WIDTH){whole_bottom_i[COORD_WIDTH-1]}}, whole_bottom_i};
    cl_x = {{(ExtW-COORD_WIDTH){clip_left_i[COORD_WIDTH-1]}},    clip_left_i};
    ct_x = {{(ExtW-COORD_WIDTH){clip_top_i[COORD_WIDTH-1]}},     clip_top_i};
    cr_x = {{(ExtW-COORD_WIDTH){clip_right_i[COORD_WIDTH-1]}},   clip_right_i};
    cb_x = {{(ExtW-COORD_WIDTH){clip_bottom_i[COORD_WIDTH-1]}},  clip_bottom_i};
    sw_x = {{(ExtW-SCREEN_W){1'b0}}, cfg_i.screen_width};
    sh_x = {{(ExtW-SCREEN_W){1'b0}}, cfg_i.screen_height};
  end

  // max of whole and clip left/top edges and zero, min of right/bottom edges and the screen
  always_comb begin
    lmax     = (wl_x > cl_x) ? wl_x : cl_x;
    tmax     = (wt_x > ct_x) ? wt_x : ct_x;
    rmin     = (wr_x < cr_x) ? wr_x : cr_x;
    bmin     = (wb_x < cb_x) ? wb_x : cb_x;
    left_d   = (lmax > 0) ? lmax : '0;
    top_d    = (tmax > 0) ? tmax : '0;
    right_d  = (rmin < sw_x) ? rmin : sw_x;
    bottom_d = (bmin < sh_x) ? bmin : sh_x;
  end

  assign s1_valid_d = s1_en ? in_valid_i : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_left_q   <= left_d;
      s1_top_q    <= top_d;
      s1_right_q  <= right_d;
      s1_bottom_q <= bottom_d;
      s1_wl_q     <= wl_x;
      s1_wt_q     <= wt_x;
      s1_op_q     <= op_i;
      s1_srcx_q   <= source_x_i;
      s1_srcy_q   <= source_y_i;
      s1_color_q  <= color_i;
    end
  end

  // empty test, clipped size and shifted source point
  always_comb begin
    nonempty = (s1_left_q < s1_right_q) && (s1_top_q < s1_bottom_q);
    width_x  = s1_right_q - s1_left_q;
    height_x = s1_bottom_q - s1_top_q;
    dx       = {s1_left_q[ExtW-1], s1_left_q} - {s1_wl_q[ExtW-1], s1_wl_q};
    dy       = {s1_top_q[ExtW-1], s1_top_q} - {s1_wt_q[ExtW-1], s1_wt_q};
    sx_d     = {{(SxW-SRC_POS_W){1'b0}}, s1_srcx_q} + dx;
    sy_d     = {{(SxW-SRC_POS_W){1'b0}}, s1_srcy_q} + dy;
  end

  // empty requests leave the pipeline here
  assign s2_valid_d = s2_en ? (s1_valid_q && nonempty) : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_op_q     <= s1_op_q;
      s2_left_q   <= s1_left_q[SIZE_W-1:0];
      s2_top_q    <= s1_top_q[SIZE_W-1:0];
      s2_width_q  <= width_x[SIZE_W-1:0];
      s2_height_q <= height_x[SIZE_W-1:0];
      s2_sx_q     <= sx_d;
      s2_sy_q     <= sy_d;
      s2_color_q  <= s1_color_q;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign out_op_o     = s2_op_q;
  assign out_left_o   = s2_left_q;
  assign out_top_o    = s2_top_q;
  assign out_width_o  = s2_width_q;
  assign out_height_o = s2_height_q;
  assign out_sx_o     = s2_sx_q;
  assign out_sy_o     = s2_sy_q;
  assign out_color_o  = s2_color_q;

  // a surviving request never has zero size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_width_q != '0))
    else $error("bcs_clip: zero width passed the empty test");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_height_q != '0))
    else $error("bcs_clip: zero height passed the empty test");

  // a held stage-1 word stays in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_en) |=> s1_valid_q)
    else $error("bcs_clip: stage-1 word lost during a stall");

endmodule

`default_nettype wire

>>> rtl/bcs_addr.sv
// ----------------------------------------------------------------------------
// bcs_addr: address generation stages
// Stage 3 forms the row and column products, stage 4 adds them into the
// destination and source addresses and holds the finished descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_addr #(
  parameter int unsigned COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH  = bcs_pkg::ADDR_WIDTH_DEF,
  localparam int unsigned SxW = bcs_pkg::src_coord_width(COORD_WIDTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bcs_pkg::cfg_t                    cfg_i,
  // clipped side
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             op_i,
  input  wire logic [bcs_pkg::SIZE_W-1:0]       left_i,
  input  wire logic [bcs_pkg::SIZE_W-1:0]       top_i,
  input  wire logic [bcs_pkg::SIZE_W-1:0]       width_i,
  input  wire logic [bcs_pkg::SIZE_W-1:0]       height_i,
  input  wire logic [SxW-1:0]                   sx_i,
  input  wire logic [SxW-1:0]                   sy_i,
  input  wire logic [bcs_pkg::COLOR_W-1:0]      color_i,
  // descriptor side
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_op_o,
  output logic [bcs_pkg::OUT_ADDR_W-1:0]        out_dest_addr_o,
  output logic [bcs_pkg::STRIDE_W-1:0]          out_dest_stride_o,
  output logic [bcs_pkg::SIZE_W-1:0]            out_width_o,
  output logic [bcs_pkg::SIZE_W-1:0]            out_height_o,
  output logic [bcs_pkg::OUT_ADDR_W-1:0]        out_src_addr_o,
  output logic [bcs_pkg::STRIDE_W-1:0]          out_src_stride_o,
  output logic [bcs_pkg::COLOR_W-1:0]           out_color_o,
  output logic [bcs_pkg::BPP_W-1:0]             out_bpp_o
);
  import bcs_pkg::*;

  // ---------------- stage 3: products ----------------
  logic                       s3_en;
  logic                       s3_valid_d, s3_valid_q;
  logic [SIZE_W+STRIDE_W-1:0] dy_prod;
  logic [SIZE_W+BPP_W-1:0]    dx_prod;
  logic [SxW+STRIDE_W-1:0]    sy_prod;
  logic [SxW+BPP_W-1:0]       sx_prod;
  logic [ADDR_WIDTH-1:0]      s3_dy_q, s3_dx_q, s3_sy_q, s3_sx_q;
  logic                       s3_op_q;
  logic [SIZE_W-1:0]          s3_width_q, s3_height_q;
  logic [COLOR_W-1:0]         s3_color_q;

  // ---------------- stage 4: sums and output word ----------------
  logic                       s4_en;
  logic                       s4_valid_d, s4_valid_q;
  logic [ADDR_WIDTH-1:0]      dest_sum, src_sum;
  logic                       s4_op_q;
  logic [OUT_ADDR_W-1:0]      s4_dest_q, s4_src_q;
  logic [STRIDE_W-1:0]        s4_dstride_q, s4_sstride_q;
  logic [SIZE_W-1:0]          s4_width_q, s4_height_q;
  logic [COLOR_W-1:0]         s4_color_q;
  logic [BPP_W-1:0]           s4_bpp_q;

  // stall chain
  assign s4_en      = !s4_valid_q || out_ready_i;
  assign s3_en      = !s3_valid_q || s4_en;
  assign in_ready_o = s3_en;

  // row and column products
  always_comb begin
    dy_prod = top_i * cfg_i.screen_stride;
    dx_prod = left_i * cfg_i.bpp;
    sy_prod = sy_i * cfg_i.screen_stride;
    sx_prod = sx_i * cfg_i.bpp;
  end

  assign s3_valid_d = s3_en ? in_valid_i : s3_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s3_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_dy_q     <= ADDR_WIDTH'(dy_prod);
      s3_dx_q     <= ADDR_WIDTH'(dx_prod);
      s3_sy_q     <= ADDR_WIDTH'(sy_prod);
      s3_sx_q     <= ADDR_WIDTH'(sx_prod);
      s3_op_q     <= op_i;
      s3_width_q  <= width_i;
      s3_height_q <= height_i;
      s3_color_q  <= color_i;
    end
  end

  // address sums wrap at the address width
  always_comb begin
    dest_sum = s3_dy_q + s3_dx_q;
    src_sum  = s3_sy_q + s3_sx_q;
  end

  assign s4_valid_d = s4_en ? s3_valid_q : s4_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s4_valid_d;
    end
  end

  // copies carry source fields, fills carry the color
  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_op_q      <= s3_op_q;
      s4_dest_q    <= OUT_ADDR_W'(dest_sum);
      s4_dstride_q <= cfg_i.screen_stride;
      s4_width_q   <= s3_width_q;
      s4_height_q  <= s3_height_q;
      s4_bpp_q     <= cfg_i.bpp;
      if (s3_op_q == OP_COPY) begin
        s4_src_q     <= OUT_ADDR_W'(src_sum);
        s4_sstride_q <= cfg_i.screen_stride;
        s4_color_q   <= '0;
      end else begin
        s4_src_q     <= '0;
        s4_sstride_q <= '0;
        s4_color_q   <= s3_color_q;
      end
    end
  end

  assign out_valid_o       = s4_valid_q;
  assign out_op_o          = s4_op_q;
  assign out_dest_addr_o   = s4_dest_q;
  assign out_dest_stride_o = s4_dstride_q;
  assign out_width_o       = s4_width_q;
  assign out_height_o      = s4_height_q;
  assign out_src_addr_o    = s4_src_q;
  assign out_src_stride_o  = s4_sstride_q;
  assign out_color_o       = s4_color_q;
  assign out_bpp_o         = s4_bpp_q;

  // a product word behind a stalled output stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s4_valid_q && !out_ready_i) |=> s3_valid_q)
    else $error("bcs_addr: stage-3 word lost during a stall");

  // a stalled descriptor word holds its addresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !out_ready_i) |=>
      (s4_valid_q && $stable(s4_dest_q) && $stable(s4_src_q)))
    else $error("bcs_addr: descriptor word changed during a stall");

  // a fill never carries source fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && (s4_op_q == OP_FILL)) |-> ((s4_src_q == '0) && (s4_sstride_q == '0)))
    else $error("bcs_addr: fill word with source fields");

endmodule

`default_nettype wire
